### src/sfb_pkg.sv
package sfb_pkg;

  localparam int unsigned CfgWords = 6;
  localparam int unsigned CfgAw    = 3;
  localparam int unsigned CfgIdxW  = 3;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;
  localparam logic [31:0] FP_XOR   = 32'h5354_554E;

  localparam logic [31:0] RST_MAGIC_COOKIE = 32'h2112_A442;
  localparam logic [31:0] RST_DATA_TYPE    = 32'h0000_0013;
  localparam logic [31:0] RST_FP_TYPE      = 32'h0000_8028;
  localparam logic [15:0] RST_MAX_PAYLOAD  = 16'd1200;
  localparam logic [15:0] RST_OUT_CAPACITY = 16'hFFFF;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_BYTE  = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TXN_HIGH,
    CFG_TXN_MIDDLE,
    CFG_TXN_LOW,
    CFG_MAGIC_COOKIE,
    CFG_DATA_ATTR_TYPE,
    CFG_FP_ATTR_TYPE,
    CFG_MAX_PAYLOAD,
    CFG_OUT_CAPACITY
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_TOO_LONG,
    ST_OVER_CAP,
    ST_NO_FRAME
  } status_e;

  typedef enum logic [1:0] {
    SRC_LIT,
    SRC_RAM,
    SRC_CRC
  } src_e;

  typedef struct packed {
    logic             valid;
    src_e             src;
    logic [CfgAw-1:0] addr;
    logic [1:0]       lane;
    logic [7:0]       lit;
    logic             crc_en;
    logic             crc_init;
    logic             last;
    status_e          status;
  } sfb_op_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

  // big endian lane select, lane 0 is the top byte
  function automatic logic [7:0] byte_of(input logic [31:0] w, input logic [1:0] lane);
    logic [7:0] b;
    unique case (lane)
      2'd0: b = w[31:24];
      2'd1: b = w[23:16];
      2'd2: b = w[15:8];
      2'd3: b = w[7:0];
    endcase
    return b;
  endfunction

  function automatic logic [31:0] cfg_reset_word(input logic [CfgAw-1:0] a);
    logic [31:0] w;
    unique case (a)
      CFG_MAGIC_COOKIE:   w = RST_MAGIC_COOKIE;
      CFG_DATA_ATTR_TYPE: w = RST_DATA_TYPE;
      CFG_FP_ATTR_TYPE:   w = RST_FP_TYPE;
      default:            w = 32'd0;
    endcase
    return w;
  endfunction

endpackage

### src/sfb_if.sv
interface sfb_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [15:0] frame_type;
  logic [15:0] data_len;
  logic [7:0]  data_byte;

  modport source (output valid, output cmd, output frame_type, output data_len,
                  output data_byte, input ready);
  modport sink (input valid, input cmd, input frame_type, input data_len,
                input data_byte, output ready);
endinterface

interface sfb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;
  logic [1:0] status;

  modport source (output valid, output out_byte, output frame_end, output status,
                  input ready);
  modport sink (input valid, input out_byte, input frame_end, input status,
                output ready);
endinterface

interface sfb_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### src/sfb_ram.sv
module sfb_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 8
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                           rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/stun_frame_builder_crc.sv
// pipeline: an accepted item's first op is registered in s1_q, its byte then in the output register
// throughput: one result byte and one payload item per cycle, absent an output stall
// a start item holds the input while the header is sent (and the fingerprint, with an empty
// payload), the last payload item while the padding and the fingerprint are sent
// reset: frame closed, crc all ones, registers back to their defaults; frame words in
// the config memory read their defaults until written
module stun_frame_builder_crc import sfb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  sfb_in_if.sink    in_i,
  sfb_out_if.source out_o,
  sfb_cfg_if.sink   cfg_i
);

  localparam logic [1:0] SQ_IDLE = 2'd0;
  localparam logic [1:0] SQ_HDR  = 2'd1;
  localparam logic [1:0] SQ_PAD  = 2'd2;
  localparam logic [1:0] SQ_FP   = 2'd3;

  logic adv;
  logic [1:0] seq_q, seq_d;
  logic [4:0] idx_q, idx_d;
  logic open_q, open_d;
  logic [15:0] rem_q, rem_d;
  logic [1:0] pad_q, pad_d;
  logic [15:0] mtype_q, mtype_d, plen_q, plen_d, body_q, body_d;
  sfb_op_t s1_q, s1_d;
  logic [31:0] crc_q, crc_d;
  logic ob_valid_q, ob_valid_d;
  logic [7:0] ob_byte_q, ob_byte_d;
  logic ob_end_q, ob_end_d;
  status_e ob_status_q, ob_status_d;
  logic [15:0] max_pay_q, cap_q;
  logic [CfgWords-1:0] cfg_vld_q;
  logic cfg_we;
  logic [CfgAw-1:0] ram_raddr;
  logic [31:0] ram_rdata, ram_word, fp_val;
  logic [7:0] b_byte;
  logic [16:0] padded;
  logic [17:0] total;

  assign adv         = !ob_valid_q || out_o.ready;
  assign in_i.ready  = adv && (seq_q == SQ_IDLE);
  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid && (cfg_i.index < 3'(CfgWords));

  assign padded = ({1'b0, in_i.data_len} + 17'd3) & ~17'd3;
  assign total  = {1'b0, padded} + 18'd32;

  // sequencer: picks the next byte and issues the config memory read
  always_comb begin
    seq_d   = seq_q;
    idx_d   = idx_q;
    open_d  = open_q;
    rem_d   = rem_q;
    pad_d   = pad_q;
    mtype_d = mtype_q;
    plen_d  = plen_q;
    body_d  = body_q;
    s1_d    = s1_q;
    if (adv) begin
      s1_d        = '0;
      s1_d.src    = SRC_LIT;
      s1_d.status = ST_OK;
      unique case (seq_q)
        SQ_IDLE: begin
          if (in_i.valid) begin
            s1_d.valid = 1'b1;
            if (in_i.cmd == CMD_START) begin
              open_d = 1'b0;
              rem_d  = 16'd0;
              pad_d  = 2'd0;
              if (in_i.data_len > max_pay_q) begin
                s1_d.last   = 1'b1;
                s1_d.status = ST_TOO_LONG;
              end else if (total > {2'b00, cap_q}) begin
                s1_d.last   = 1'b1;
                s1_d.status = ST_OVER_CAP;
              end else begin
                mtype_d       = in_i.frame_type;
                plen_d        = in_i.data_len;
                body_d        = 16'(padded + 17'd12);
                rem_d         = in_i.data_len;
                pad_d         = 2'd0 - in_i.data_len[1:0];
                open_d        = (in_i.data_len != 16'd0);
                seq_d         = SQ_HDR;
                idx_d         = 5'd1;
                s1_d.lit      = in_i.frame_type[15:8];
                s1_d.crc_en   = 1'b1;
                s1_d.crc_init = 1'b1;
              end
            end else if (!open_q) begin
              s1_d.last   = 1'b1;
              s1_d.status = ST_NO_FRAME;
            end else begin
              s1_d.lit    = in_i.data_byte;
              s1_d.crc_en = 1'b1;
              rem_d       = rem_q - 16'd1;
              if (rem_q == 16'd1) begin
                open_d = 1'b0;
                seq_d  = (pad_q != 2'd0) ? SQ_PAD : SQ_FP;
                idx_d  = 5'd0;
              end
            end
          end
        end
        SQ_HDR: begin
          s1_d.valid  = 1'b1;
          s1_d.crc_en = 1'b1;
          s1_d.lane   = idx_q[1:0];
          unique case (idx_q[4:2])
            3'd0: s1_d.lit = byte_of({mtype_q, body_q}, idx_q[1:0]);
            3'd1: begin
              s1_d.src  = SRC_RAM;
              s1_d.addr = CFG_MAGIC_COOKIE;
            end
            3'd2: begin
              s1_d.src  = SRC_RAM;
              s1_d.addr = CFG_TXN_HIGH;
            end
            3'd3: begin
              s1_d.src  = SRC_RAM;
              s1_d.addr = CFG_TXN_MIDDLE;
            end
            3'd4: begin
              s1_d.src  = SRC_RAM;
              s1_d.addr = CFG_TXN_LOW;
            end
            3'd5: begin
              if (!idx_q[1]) begin
                s1_d.src  = SRC_RAM;
                s1_d.addr = CFG_DATA_ATTR_TYPE;
                s1_d.lane = {1'b1, idx_q[0]};
              end else begin
                s1_d.lit = byte_of({plen_q, plen_q}, idx_q[1:0]);
              end
            end
            default: s1_d.lit = 8'd0;
          endcase
          idx_d = idx_q + 5'd1;
          if (idx_q == 5'd23) begin
            idx_d = 5'd0;
            seq_d = (plen_q == 16'd0) ? SQ_FP : SQ_IDLE;
          end
        end
        SQ_PAD: begin
          s1_d.valid  = 1'b1;
          s1_d.crc_en = 1'b1;
          pad_d       = pad_q - 2'd1;
          if (pad_q == 2'd1) begin
            seq_d = SQ_FP;
            idx_d = 5'd0;
          end
        end
        SQ_FP: begin
          s1_d.valid = 1'b1;
          s1_d.lane  = idx_q[1:0];
          unique case (idx_q[2:0])
            3'd0, 3'd1: begin
              s1_d.src  = SRC_RAM;
              s1_d.addr = CFG_FP_ATTR_TYPE;
              s1_d.lane = {1'b1, idx_q[0]};
            end
            3'd2: s1_d.lit = 8'd0;
            3'd3: s1_d.lit = 8'd4;
            default: s1_d.src = SRC_CRC;
          endcase
          idx_d = idx_q + 5'd1;
          if (idx_q[2:0] == 3'd7) begin
            s1_d.last = 1'b1;
            idx_d     = 5'd0;
            seq_d     = SQ_IDLE;
          end
        end
        default: seq_d = SQ_IDLE;
      endcase
    end
    ram_raddr = s1_d.addr;
  end

  sfb_ram #(
    .Width(32),
    .Depth(CfgWords)
  ) u_cfg_ram (
    .clk_i  (clk_i),
    .we_i   (cfg_we),
    .waddr_i(cfg_i.index),
    .wdata_i(cfg_i.data),
    .re_i   (adv),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // byte stage: memory data is aligned with s1_q here
  always_comb begin
    ram_word = cfg_vld_q[s1_q.addr] ? ram_rdata : cfg_reset_word(s1_q.addr);
    fp_val   = ~crc_q ^ FP_XOR;
    unique case (s1_q.src)
      SRC_RAM: b_byte = byte_of(ram_word, s1_q.lane);
      SRC_CRC: b_byte = byte_of(fp_val, s1_q.lane);
      default: b_byte = s1_q.lit;
    endcase
    crc_d       = crc_q;
    ob_valid_d  = ob_valid_q;
    ob_byte_d   = ob_byte_q;
    ob_end_d    = ob_end_q;
    ob_status_d = ob_status_q;
    if (adv) begin
      ob_valid_d  = s1_q.valid;
      ob_byte_d   = b_byte;
      ob_end_d    = s1_q.last;
      ob_status_d = s1_q.status;
      if (s1_q.valid && s1_q.crc_en) begin
        crc_d = crc_byte(s1_q.crc_init ? CRC_ONES : crc_q, b_byte);
      end
    end
  end

  assign out_o.valid     = ob_valid_q;
  assign out_o.out_byte  = ob_byte_q;
  assign out_o.frame_end = ob_end_q;
  assign out_o.status    = ob_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= SQ_IDLE;
      idx_q       <= 5'd0;
      open_q      <= 1'b0;
      rem_q       <= 16'd0;
      pad_q       <= 2'd0;
      s1_q        <= '0;
      crc_q       <= CRC_ONES;
      ob_valid_q  <= 1'b0;
      ob_end_q    <= 1'b0;
      ob_status_q <= ST_OK;
      max_pay_q   <= RST_MAX_PAYLOAD;
      cap_q       <= RST_OUT_CAPACITY;
      cfg_vld_q   <= '0;
    end else begin
      seq_q       <= seq_d;
      idx_q       <= idx_d;
      open_q      <= open_d;
      rem_q       <= rem_d;
      pad_q       <= pad_d;
      s1_q        <= s1_d;
      crc_q       <= crc_d;
      ob_valid_q  <= ob_valid_d;
      ob_end_q    <= ob_end_d;
      ob_status_q <= ob_status_d;
      if (cfg_we) begin
        cfg_vld_q[cfg_i.index] <= 1'b1;
      end
      if (cfg_i.valid && (cfg_i.index == CFG_MAX_PAYLOAD)) begin
        max_pay_q <= cfg_i.data[15:0];
      end
      if (cfg_i.valid && (cfg_i.index == CFG_OUT_CAPACITY)) begin
        cap_q <= cfg_i.data[15:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mtype_q   <= mtype_d;
    plen_q    <= plen_d;
    body_q    <= body_d;
    ob_byte_q <= ob_byte_d;
  end

  a_err_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ob_valid_q && (ob_status_q != ST_OK) |-> ob_end_q)
    else $error("error item without frame end");

  a_pad_done_in_fp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == SQ_FP) |-> (pad_q == 2'd0))
    else $error("fingerprint started with padding left");

  a_closed_no_remaining: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !open_q |-> (rem_q == 16'd0))
    else $error("closed frame with bytes remaining");

  a_stall_holds_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(s1_q))
    else $error("byte stage op changed during stall");

endmodule

### dv/tb.sv
module tb;
  import sfb_pkg::*;

  typedef struct {
    logic [7:0] value;
    logic       last;
    status_e    status;
  } frame_byte_t;

  class frame_byte_scoreboard;
    frame_byte_t due[$];
    int unsigned mismatches;
    logic [31:0] txn_hi, txn_mid, txn_lo, cookie;
    logic [15:0] data_type, fp_type, max_len, capacity;
    logic [31:0] crc;
    logic [15:0] left;
    logic [1:0]  pad;
    logic        open;

    function void clear_frame();
      crc  = CRC_ONES;
      left = '0;
      pad  = '0;
      open = 1'b0;
    endfunction

    function new();
      txn_hi     = '0;
      txn_mid    = '0;
      txn_lo     = '0;
      cookie     = RST_MAGIC_COOKIE;
      data_type  = RST_DATA_TYPE[15:0];
      fp_type    = RST_FP_TYPE[15:0];
      max_len    = RST_MAX_PAYLOAD;
      capacity   = RST_OUT_CAPACITY;
      mismatches = 0;
      clear_frame();
    endfunction

    function void set_reg(cfg_idx_e idx, logic [31:0] d);
      case (idx)
        CFG_TXN_HIGH:       txn_hi = d;
        CFG_TXN_MIDDLE:     txn_mid = d;
        CFG_TXN_LOW:        txn_lo = d;
        CFG_MAGIC_COOKIE:   cookie = d;
        CFG_DATA_ATTR_TYPE: data_type = d[15:0];
        CFG_FP_ATTR_TYPE:   fp_type = d[15:0];
        CFG_MAX_PAYLOAD:    max_len = d[15:0];
        CFG_OUT_CAPACITY:   capacity = d[15:0];
        default: ;
      endcase
    endfunction

    function void emit(logic [7:0] b, logic fold);
      due.push_back(frame_byte_t'{value: b, last: 1'b0, status: ST_OK});
      if (fold) begin
        crc = crc ^ {24'd0, b};
        repeat (8) crc = (crc >> 1) ^ (crc[0] ? CRC_POLY : 32'd0);
      end
    endfunction

    function void emit_be(logic [31:0] w, int nbytes);
      for (int i = nbytes - 1; i >= 0; i--) emit(w[8*i +: 8], 1'b1);
    endfunction

    function void emit_error(status_e st);
      due.push_back(frame_byte_t'{value: 8'h00, last: 1'b1, status: st});
    endfunction

    // padding, then the fingerprint attribute, which is not folded into the crc
    function void emit_fingerprint();
      logic [31:0] fp;
      repeat (pad) emit(8'h00, 1'b1);
      emit(fp_type[15:8], 1'b0);
      emit(fp_type[7:0], 1'b0);
      emit(8'h00, 1'b0);
      emit(8'd4, 1'b0);
      fp = ~crc ^ FP_XOR;
      emit(fp[31:24], 1'b0);
      emit(fp[23:16], 1'b0);
      emit(fp[15:8], 1'b0);
      due.push_back(frame_byte_t'{value: fp[7:0], last: 1'b1, status: ST_OK});
      clear_frame();
    endfunction

    function void take_item(logic cmd, logic [15:0] mt, logic [15:0] plen, logic [7:0] db);
      logic [16:0] padded;
      logic [17:0] body;
      padded = ({1'b0, plen} + 17'd3) & ~17'd3;
      body   = 18'd12 + {1'b0, padded};
      if (cmd == CMD_START) begin
        clear_frame();
        if (plen > max_len) begin
          emit_error(ST_TOO_LONG);
        end else if (body + 18'd20 > {2'b00, capacity}) begin
          emit_error(ST_OVER_CAP);
        end else begin
          emit_be({16'd0, mt}, 2);
          emit_be({16'd0, body[15:0]}, 2);
          emit_be(cookie, 4);
          emit_be(txn_hi, 4);
          emit_be(txn_mid, 4);
          emit_be(txn_lo, 4);
          emit_be({16'd0, data_type}, 2);
          emit_be({16'd0, plen}, 2);
          left = plen;
          pad  = 2'd0 - plen[1:0];
          open = 1'b1;
          if (plen == 16'd0) emit_fingerprint();
        end
      end else if (!open) begin
        emit_error(ST_NO_FRAME);
      end else begin
        emit(db, 1'b1);
        left = left - 16'd1;
        if (left == 16'd0) emit_fingerprint();
      end
    endfunction

    function void check_byte(logic [7:0] b, logic last, logic [1:0] st);
      frame_byte_t exp_b;
      if (due.size() == 0) begin
        $display("%0t unexpected result: byte %02h end %0b status %0d", $time, b, last, st);
        mismatches++;
        return;
      end
      exp_b = due.pop_front();
      if (exp_b.value !== b || exp_b.last !== last || exp_b.status !== st) begin
        $display({"%0t mismatch: expected byte %02h end %0b status %0d, ",
                  "got byte %02h end %0b status %0d"},
                 $time, exp_b.value, exp_b.last, exp_b.status, b, last, st);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  sfb_in_if  in_if();
  sfb_out_if out_if();
  sfb_cfg_if cfg_if();

  stun_frame_builder_crc u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  frame_byte_scoreboard sb;
  int   burst_left = 0;
  int   rx_cycle = 0;
  int   hold_left = 0;
  logic hold_request = 1'b0;
  int   items_taken = 0;

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        sb.check_byte(out_if.out_byte, out_if.frame_end, out_if.status);
      end
      if (in_if.valid === 1'b1 && in_if.ready === 1'b1) begin
        sb.take_item(in_if.cmd, in_if.frame_type, in_if.data_len, in_if.data_byte);
      end
      if (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1) begin
        sb.set_reg(cfg_idx_e'(cfg_if.index), cfg_if.data);
      end
    end
  end

  // accepted input items, counted at the handshake
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && in_if.valid === 1'b1 && in_if.ready === 1'b1) begin
      items_taken <= items_taken + 1;
    end
  end

  function automatic int in_if_count();
    return items_taken;
  endfunction

  // receiver stall pattern, with a long hold-off on request
  always @(posedge clk_i) begin
    rx_cycle <= rx_cycle + 1;
    if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else if (hold_request) begin
      hold_left    <= 300;
      hold_request <= 1'b0;
      out_if.ready <= 1'b0;
    end else begin
      case (rx_cycle[8:7])
        2'd0:    out_if.ready <= 1'b1;
        2'd1:    out_if.ready <= 1'($urandom_range(0, 1));
        2'd2:    out_if.ready <= (rx_cycle % 5 != 0);
        default: out_if.ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  task automatic send_item(logic cmd, logic [15:0] mt, logic [15:0] plen, logic [7:0] db);
    int gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(0, 5);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_if.valid      <= 1'b1;
    in_if.cmd        <= cmd;
    in_if.frame_type <= mt;
    in_if.data_len   <= plen;
    in_if.data_byte  <= db;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
  endtask

  task automatic send_start(logic [15:0] mt, logic [15:0] plen);
    send_item(CMD_START, mt, plen, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_byte(logic [7:0] b);
    send_item(CMD_BYTE, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), b);
  endtask

  task automatic send_frame(logic [15:0] mt, int plen);
    send_start(mt, 16'(plen));
    repeat (plen) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.due.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] d);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_all(logic [31:0] hi, logic [31:0] mid, logic [31:0] lo, logic [31:0] ck,
                           logic [15:0] dt, logic [15:0] ft, logic [15:0] mx, logic [15:0] cap);
    write_reg(CFG_TXN_HIGH, hi);
    write_reg(CFG_TXN_MIDDLE, mid);
    write_reg(CFG_TXN_LOW, lo);
    write_reg(CFG_MAGIC_COOKIE, ck);
    write_reg(CFG_DATA_ATTR_TYPE, {16'd0, dt});
    write_reg(CFG_FP_ATTR_TYPE, {16'd0, ft});
    write_reg(CFG_MAX_PAYLOAD, {16'd0, mx});
    write_reg(CFG_OUT_CAPACITY, {16'd0, cap});
  endtask

  // longest payload that still fits both limits, small frames only
  function automatic int fit_limit();
    int room;
    room = int'(sb.capacity) - 32;
    if (room < 0) return -1;
    room = room & ~3;
    if (room > int'(sb.max_len)) room = int'(sb.max_len);
    if (room > 40) room = 40;
    return room;
  endfunction

  task automatic random_frame();
    int kind;
    int lim;
    int plen;
    int cut;
    kind = $urandom_range(0, 99);
    lim  = fit_limit();
    if (kind < 85 && lim >= 0) begin
      plen = $urandom_range(0, lim);
      if (kind >= 72 && plen >= 2) begin
        // cut short, the next start drops it
        cut = $urandom_range(1, plen - 1);
        send_start(16'($urandom_range(0, 65535)), 16'(plen));
        repeat (cut) send_byte(8'($urandom_range(0, 255)));
        plen = $urandom_range(0, lim);
      end
      send_frame(16'($urandom_range(0, 65535)), plen);
    end else if (kind < 92) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
    end else if (kind < 97) begin
      send_start(16'($urandom_range(0, 65535)),
                 16'($urandom_range(int'(sb.max_len) + 1, 65535)));
    end else begin
      send_start(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    end
  endtask

  initial begin
    int target;
    sb = new();
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.cmd        = CMD_START;
    in_if.frame_type = '0;
    in_if.data_len   = '0;
    in_if.data_byte  = '0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = '0;
    cfg_if.data      = '0;
    out_if.ready     = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // defaults after reset
    send_byte(8'hFF);
    send_start(16'hFFFF, 16'd0);
    send_start(16'h0001, 16'd2);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_start(16'h0101, 16'd3);
    send_byte(8'h5A);
    send_byte(8'hA5);
    send_byte(8'h3C);
    send_start(16'h8000, 16'd1201);
    send_start(16'h0000, 16'hFFFF);
    send_start(16'h0115, 16'd5);
    send_byte(8'h81);
    send_frame(16'h0111, 4);
    wait_idle();

    // every frame word at its top value, payload and capacity limits near theirs
    write_all('1, '1, '1, '1, 16'hFFFF, 16'hFFFF, 16'd65500, 16'd65530);
    send_start(16'h0001, 16'd65500);
    send_start(16'h0001, 16'd65501);
    send_frame(16'h7FFF, 1);
    send_byte(8'h7E);
    wait_idle();

    // every register at zero
    write_all('0, '0, '0, '0, 16'h0000, 16'h0000, 16'd0, 16'd0);
    send_start(16'h0001, 16'd0);
    send_start(16'h0001, 16'd1);
    send_byte(8'h01);
    wait_idle();
    write_reg(CFG_OUT_CAPACITY, 32'd32);
    send_start(16'h0000, 16'd0);
    wait_idle();

    target = 25;
    for (int round = 0; round < 4; round++) begin
      if (round == 0) begin
        write_all($urandom, $urandom, $urandom, $urandom, 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)), 16'd65500, 16'hFFFF);
        // long output hold-off while a long frame keeps arriving
        hold_request <= 1'b1;
        send_frame(16'($urandom_range(0, 65535)), 40);
      end else begin
        write_all($urandom, $urandom, $urandom, $urandom, 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)),
                  (round == 1) ? 16'($urandom_range(0, 32)) : 16'($urandom_range(0, 65500)),
                  (round == 3) ? 16'($urandom_range(24, 120)) : 16'($urandom_range(0, 65535)));
      end
      target += 60;
      while (in_if_count() < target) random_frame();
      send_start(16'($urandom_range(0, 65535)), 16'd0);
      wait_idle();
    end

    if (sb.mismatches == 0 && sb.due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
